// File: rtl/core/box_blur_3x3_edge_aware_assert.svh
// ----------------------------------------------------------------------------
// box blur assertion macros
// shared property shapes for the box blur checkers
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// types and constants shared by the box blur datapath
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

    localparam int unsigned NCH      = 3;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned COLSUM_W = 10;
    localparam int unsigned SUM_W    = 12;
    localparam int unsigned FW_W     = 12;
    localparam int unsigned FH_W     = 13;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam int unsigned MAX_HEIGHT = 4096;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd4096;

    // reciprocals scaled by 2^15, exact for rounded sums below 4096
    localparam int unsigned     RECIP_SHIFT = 15;
    localparam int unsigned     RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_9  = 13'd3641;
    localparam logic [RECIP_W-1:0] RECIP_6  = 13'd5462;

    // result kinds released by one pixel, in delivery order
    localparam int unsigned RES_MAIN   = 0;
    localparam int unsigned RES_RIGHT  = 1;
    localparam int unsigned RES_BELOW  = 2;
    localparam int unsigned RES_CORNER = 3;
    localparam int unsigned RES_N      = 4;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    // index 0 is red, 1 green, 2 blue
    typedef logic [NCH-1:0][PIX_W-1:0] t_pixel;
    typedef logic [NCH-1:0][SUM_W-1:0] t_sums;

    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_word;

    typedef struct packed {
        logic has;
        logic top;
        logic left;
        logic last_col;
        logic last_row;
    } t_pos;

    typedef struct packed {
        t_div div;
        logic done;
        logic last;
    } t_mean_ctl;

    function automatic logic [ROW_W-1:0] last_row_of(input logic [FH_W-1:0] h);
        logic [FH_W-1:0] m;
        if (h < FH_W'(2)) begin
            m = FH_W'(2);
        end else if (h > FH_W'(MAX_HEIGHT)) begin
            m = FH_W'(MAX_HEIGHT);
        end else begin
            m = h;
        end
        return ROW_W'(m - FH_W'(1));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bblur_div.sv
// ----------------------------------------------------------------------------
// bblur_div
// rounded division of channel sums by 4, 6 or 9, with the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  bblur_pkg::t_sums      i_sum,
    input  bblur_pkg::t_mean_ctl  i_ctl,
    output logic                  o_ready,
    output logic                  o_valid,
    output bblur_pkg::t_pixel     o_mean,
    output bblur_pkg::t_mean_ctl  o_ctl,
    input  logic                  i_stall
);
    import bblur_pkg::*;

    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    logic                          r_valid;
    t_pixel                        r_mean;
    t_mean_ctl                     r_ctl;
    t_pixel                        n_mean;
    logic [SUM_W-1:0]              half;
    logic [RECIP_W-1:0]            recip;
    logic [NCH-1:0][SUM_W-1:0]     rnd;
    logic [NCH-1:0][PROD_W-1:0]    prod;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_mean  = r_mean;
    assign o_ctl   = r_ctl;

    always_comb begin
        case (i_ctl.div)
            DIV_9: begin
                half  = SUM_W'(4);
                recip = RECIP_9;
            end
            DIV_6: begin
                half  = SUM_W'(3);
                recip = RECIP_6;
            end
            default: begin
                half  = SUM_W'(2);
                recip = RECIP_6;
            end
        endcase
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            rnd[ch]  = i_sum[ch] + half;
            prod[ch] = PROD_W'(rnd[ch]) * PROD_W'(recip);
            case (i_ctl.div)
                DIV_9, DIV_6: n_mean[ch] = prod[ch][RECIP_SHIFT +: PIX_W];
                DIV_4:        n_mean[ch] = rnd[ch][2 +: PIX_W];
                default:      n_mean[ch] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mean <= n_mean;
            r_ctl  <= i_ctl;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/box_blur_3x3_edge_aware.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// edge-aware 3x3 box blur on a raster rgb stream, rounded mean per channel
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | words
//  --------+-----------+--------------------------+-----------------------------
//  config  | in        | psel/penable/pwrite      | frame_width, frame_height
//  pixel   | in        | i_in_valid / o_in_stall  | one rgb pixel
//  blur    | out       | o_out_valid / i_out_stall| rgb mean, frame_done, last
//
//  one pixel per cycle while o_in_stall is low; a word passes the read, window
//  and sum registers before it reaches the output register
//  the output register delivers one word per cycle while i_out_stall is low, so
//  a pixel releasing two to four words (last column, last row) holds the input
//  until its last word is emitted; line stores sit in one memory of MAX_WIDTH
//  entries, read on accept and written back as the pixel enters the window;
//  reset leaves them as they are
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_aware #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bblur_pkg::APB_AW-1:0]  paddr,
    input  logic [bblur_pkg::APB_DW-1:0]  pwdata,
    output logic [bblur_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_red,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_green,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_blue,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bblur_pkg::PIX_W-1:0]   o_blurred_red,
    output logic [bblur_pkg::PIX_W-1:0]   o_blurred_green,
    output logic [bblur_pkg::PIX_W-1:0]   o_blurred_blue,
    output logic                          o_frame_done,
    output logic                          o_last_of_run
);
    import bblur_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    function automatic logic [COL_W-1:0] col_last_of(input logic [FW_W-1:0] w);
        logic [31:0] m;
        m = 32'(w);
        if (m < 32'd2) begin
            m = 32'd2;
        end else if (m > MAX_WIDTH) begin
            m = MAX_WIDTH;
        end
        return COL_W'(m - 32'd1);
    endfunction

    // configuration
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [COL_W-1:0]  r_col_last;
    logic [ROW_W-1:0]  r_row_last;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    // position of the next pixel
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    // line store memory, upper and middle rows side by side
    t_line_word        r_line_mem [MAX_WIDTH];
    t_line_word        r_line_rd;

    // read stage
    logic              r_s1_valid;
    t_pixel            r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    t_pos              r_s1_pos;
    t_pos              s1_pos;

    // window stage, [column c-2..c][row r-2..r]
    t_pixel            r_win [3][3];
    logic [RES_N-1:0]  r_s2_pend;
    logic              r_s2_top;
    logic              r_s2_left;
    logic [RES_N-1:0]  sel;
    logic [RES_N-1:0]  pend_rest;
    logic [RES_N-1:0]  pend_load;
    logic              row_full;
    logic              col_full;
    logic [2:0][NCH-1:0][COLSUM_W-1:0] col_sum;
    t_sums             n_sum;
    t_mean_ctl         n_ctl;

    // sum stage
    logic              r_s3_valid;
    t_sums             r_s3_sum;
    t_mean_ctl         r_s3_ctl;

    // handshake
    logic              in_acc;
    logic              s1_adv;
    logic              s2_free;
    logic              s3_free;
    logic              emit;
    logic              div_ready;
    t_pixel            div_mean;
    t_mean_ctl         div_ctl;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col_last     <= col_last_of(FRAME_WIDTH_RST);
            r_row_last     <= last_row_of(FRAME_HEIGHT_RST);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[FW_W-1:0];
                    r_col_last    <= col_last_of(pwdata[FW_W-1:0]);
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[FH_W-1:0];
                    r_row_last     <= last_row_of(pwdata[FH_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stall chain, output side back to input side
    // ------------------------------------------------------------------------
    assign s3_free    = !r_s3_valid || div_ready;
    assign emit       = (r_s2_pend != '0) && s3_free;
    assign s2_free    = (r_s2_pend == '0) || (emit && (pend_rest == '0));
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (r_col == r_col_last) begin
                n_col = '0;
                n_row = (r_row == r_row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        s1_pos.has      = (r_row != '0) && (r_col != '0);
        s1_pos.top      = r_row > ROW_W'(1);
        s1_pos.left     = r_col > COL_W'(1);
        s1_pos.last_col = r_col == r_col_last;
        s1_pos.last_row = r_row == r_row_last;
    end

    // ------------------------------------------------------------------------
    // line store: read on accept, write back when the pixel enters the window
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_rd <= r_line_mem[r_col];
        end
        if (s1_adv) begin
            r_line_mem[r_s1_col] <= '{upper: r_line_rd.middle, middle: r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= {i_pixel_blue, i_pixel_green, i_pixel_red};
            r_s1_col <= r_col;
            r_s1_pos <= s1_pos;
        end
    end

    // ------------------------------------------------------------------------
    // column window and result sequencing
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= r_line_rd.upper;
            r_win[2][1] <= r_line_rd.middle;
            r_win[2][2] <= r_s1_pix;
            r_s2_top    <= r_s1_pos.top;
            r_s2_left   <= r_s1_pos.left;
        end
    end

    always_comb begin
        pend_load             = '0;
        pend_load[RES_MAIN]   = r_s1_pos.has;
        pend_load[RES_RIGHT]  = r_s1_pos.has && r_s1_pos.last_col;
        pend_load[RES_BELOW]  = r_s1_pos.has && r_s1_pos.last_row;
        pend_load[RES_CORNER] = r_s1_pos.has && r_s1_pos.last_col && r_s1_pos.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_pend <= '0;
        end else if (s1_adv) begin
            r_s2_pend <= pend_load;
        end else if (emit) begin
            r_s2_pend <= pend_rest;
        end
    end

    // lowest pending kind goes first
    assign sel       = r_s2_pend & (~r_s2_pend + RES_N'(1));
    assign pend_rest = r_s2_pend & ~sel;
    assign row_full  = r_s2_top && (sel[RES_MAIN] || sel[RES_RIGHT]);
    assign col_full  = r_s2_left && (sel[RES_MAIN] || sel[RES_BELOW]);

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int ci = 0; ci < 3; ci++) begin
                col_sum[ci][ch] = (row_full ? COLSUM_W'(r_win[ci][0][ch]) : '0)
                    + COLSUM_W'(r_win[ci][1][ch]) + COLSUM_W'(r_win[ci][2][ch]);
            end
            n_sum[ch] = (col_full ? SUM_W'(col_sum[0][ch]) : '0)
                + SUM_W'(col_sum[1][ch]) + SUM_W'(col_sum[2][ch]);
        end
    end

    always_comb begin
        if (row_full && col_full) begin
            n_ctl.div = DIV_9;
        end else if (row_full || col_full) begin
            n_ctl.div = DIV_6;
        end else begin
            n_ctl.div = DIV_4;
        end
        n_ctl.done = sel[RES_CORNER];
        n_ctl.last = pend_rest == '0;
    end

    // ------------------------------------------------------------------------
    // sum register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (emit) begin
            r_s3_valid <= 1'b1;
        end else if (div_ready) begin
            r_s3_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s3_sum <= n_sum;
            r_s3_ctl <= n_ctl;
        end
    end

    bblur_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_sum   (r_s3_sum),
        .i_ctl   (r_s3_ctl),
        .o_ready (div_ready),
        .o_valid (o_out_valid),
        .o_mean  (div_mean),
        .o_ctl   (div_ctl),
        .i_stall (i_out_stall)
    );

    assign o_blurred_red   = div_mean[0];
    assign o_blurred_green = div_mean[1];
    assign o_blurred_blue  = div_mean[2];
    assign o_frame_done    = div_ctl.done;
    assign o_last_of_run   = div_ctl.last;

endmodule

`default_nettype wire

// File: rtl/core/bblur_chk.sv
// ----------------------------------------------------------------------------
// bblur_chk
// port-level checks on the box blur, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_edge_aware_assert.svh"

module bblur_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bblur_pkg::APB_AW-1:0]  paddr,
    input  logic [bblur_pkg::APB_DW-1:0]  pwdata,
    input  logic [bblur_pkg::APB_DW-1:0]  prdata,
    input  logic                          pready,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_red,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_green,
    input  logic [bblur_pkg::PIX_W-1:0]   i_pixel_blue,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [bblur_pkg::PIX_W-1:0]   o_blurred_red,
    input  logic [bblur_pkg::PIX_W-1:0]   o_blurred_green,
    input  logic [bblur_pkg::PIX_W-1:0]   o_blurred_blue,
    input  logic                          o_frame_done,
    input  logic                          o_last_of_run
);

    // a stalled pixel word holds
    `BB_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, (i_in_valid && $stable({i_pixel_red, i_pixel_green, i_pixel_blue})), "pixel word changed under stall")

    // a stalled word holds
    `BB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, (o_out_valid && $stable({o_blurred_red, o_blurred_green, o_blurred_blue, o_frame_done, o_last_of_run})), "blur word changed under stall")

    // width reads back what was written
    `BB_ASSERT_NXT(a_width_rd, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[2], (paddr[2] || (prdata[11:0] == $past(pwdata[11:0]))), "frame width readback wrong")

    // height reads back what was written
    `BB_ASSERT_NXT(a_height_rd, i_clk, i_rst_n, psel && penable && pwrite && pready && paddr[2], (!paddr[2] || (prdata[12:0] == $past(pwdata[12:0]))), "frame height readback wrong")

    // a frame end is never followed at once by another
    `BB_ASSERT_NXT(a_done_gap, i_clk, i_rst_n, o_out_valid && o_frame_done && !i_out_stall, (!(o_out_valid && o_frame_done)), "frame end repeated")

endmodule

bind box_blur_3x3_edge_aware bblur_chk u_bblur_chk (.*);

`default_nettype wire
